>>> rtl/core/bsa_pkg.sv
// Shared constants, command codes and controller interface types.
`timescale 1ns / 1ps
`default_nettype none
package bsa_pkg;

    localparam int MAX_BINS = 64;
    localparam int ADDR_W   = $clog2(MAX_BINS);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int CELL_AW  = 2 * ADDR_W;
    localparam int CELLS    = MAX_BINS * MAX_BINS;

    localparam int SMP_W    = 16;
    localparam int BIN_W    = 6;
    localparam int CMD_W    = 2;
    localparam int CELL_W   = 63;
    localparam int POW_W    = 52;
    localparam int FRM_W    = 20;
    localparam int ORDER_W  = 2;
    localparam int BINS_W   = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_BINS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BINS = 2'd2;

    localparam logic [ORDER_W-1:0] ORDER_CROSS  = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_TRIPLE = 2'd2;

    typedef struct packed {
        logic ld_wr;
        logic rd_lat;
        logic rd_mode;
        logic out_load;
        logic clr_start;
        logic clr_wr;
        logic frm_clr;
        logic frm_inc;
        logic idx_clr;
        logic cell_next;
        logic m1_en;
        logic m2_en;
        logic m3_en;
        logic m4_en;
        logic cell_wr;
        logic sq_en;
        logic pw_wr;
        logic pw_sel_y;
    } ctrl_t;

    typedef struct packed {
        logic cells_done;
        logic skip;
        logic pw_x_done;
        logic pw_y_done;
        logic clr_last;
        logic order2;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

>>> rtl/core/bsa_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/core/bsa_datapath.sv
// Datapath: frame buffers, accumulator memories, multipliers, counters, output word.
`timescale 1ns / 1ps
`default_nettype none
module bsa_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsa_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [bsa_pkg::BIN_W-1:0]     s_bin_index,
    input  wire logic signed [bsa_pkg::SMP_W-1:0] s_x_real,
    input  wire logic signed [bsa_pkg::SMP_W-1:0] s_x_imag,
    input  wire logic signed [bsa_pkg::SMP_W-1:0] s_y_real,
    input  wire logic signed [bsa_pkg::SMP_W-1:0] s_y_imag,
    input  wire logic [bsa_pkg::BIN_W-1:0]     s_row,
    input  wire logic [bsa_pkg::BIN_W-1:0]     s_col,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic signed [bsa_pkg::CELL_W-1:0]  m_sum_real,
    output logic signed [bsa_pkg::CELL_W-1:0]  m_sum_imag,
    output logic [bsa_pkg::POW_W-1:0]          m_row_power,
    output logic [bsa_pkg::POW_W-1:0]          m_col_power,
    output logic [bsa_pkg::POW_W-1:0]          m_diag_power,
    output logic [bsa_pkg::FRM_W-1:0]          m_frames,
    input  wire bsa_pkg::ctrl_t                ctrl,
    output bsa_pkg::status_t                   status
);
    import bsa_pkg::*;

    logic [ORDER_W-1:0] order_reg;
    logic [BINS_W-1:0]  x_bins_reg, y_bins_reg;
    logic [CNT_W-1:0]   nx, ny;
    logic               order2;

    logic [CNT_W-1:0]   i_reg, j_reg;
    logic [CNT_W:0]     ij_sum;
    logic [CELL_AW-1:0] clr_cnt_reg;
    logic               clr_in_pow;
    logic [FRM_W-1:0]   frame_cnt_reg;
    logic [ADDR_W-1:0]  row_reg, col_reg;
    logic [CNT_W:0]     rc_sum;

    logic [2*SMP_W-1:0] fa_q, fb_q, fy_q;
    logic [CELL_W-1:0]  cr_q, ci_q;
    logic [POW_W-1:0]   xpa_q, xpb_q, yp_q;

    logic signed [SMP_W-1:0] xr, xi, yr, yi, kr, ki, pr_s, pm_s;
    logic signed [31:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [32:0] a_reg, b_reg;
    logic signed [48:0] q1_reg, q2_reg, q3_reg, q4_reg;
    logic signed [49:0] tre_reg, tim_reg;
    logic signed [31:0] sq1_reg, sq2_reg;

    logic signed [CELL_W-1:0] cr_s, ci_s;
    logic signed [63:0] sre, sim;
    logic [CELL_W-1:0]  sat_re, sat_im;
    logic [32:0]        pw_term;
    logic [POW_W-1:0]   pw_acc, pw_sat;
    logic [POW_W:0]     pw_sum;

    logic               cell_we, xp_we, yp_we;
    logic [CELL_AW-1:0] cell_wa, cell_ra;
    logic [ADDR_W-1:0]  pw_wa;
    logic [POW_W-1:0]   pw_wd;
    logic               m_valid_reg;

    function automatic logic [CELL_W-1:0] sat_cell(input logic signed [63:0] s);
        logic [CELL_W-1:0] r;
        if (s[63] != s[62]) begin
            r = s[63] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
        end else begin
            r = s[CELL_W-1:0];
        end
        return r;
    endfunction

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg  <= ORDER_CROSS;
            x_bins_reg <= BINS_W'(MAX_BINS);
            y_bins_reg <= BINS_W'(MAX_BINS);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ORDER:  order_reg  <= cfg_data[ORDER_W-1:0];
                REG_X_BINS: x_bins_reg <= cfg_data[BINS_W-1:0];
                REG_Y_BINS: y_bins_reg <= cfg_data[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    assign nx = (x_bins_reg > BINS_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : CNT_W'(x_bins_reg);
    assign ny = (y_bins_reg > BINS_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : CNT_W'(y_bins_reg);
    assign order2 = (order_reg == ORDER_TRIPLE);

    // sweep indexes, also reused as the bin index of the power passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg <= '0;
            j_reg <= '0;
        end else if (ctrl.idx_clr) begin
            i_reg <= '0;
            j_reg <= '0;
        end else if (ctrl.cell_next) begin
            if ((j_reg + CNT_W'(1)) >= ny) begin
                j_reg <= '0;
                i_reg <= i_reg + CNT_W'(1);
            end else begin
                j_reg <= j_reg + CNT_W'(1);
            end
        end else if (ctrl.pw_wr) begin
            i_reg <= i_reg + CNT_W'(1);
        end
    end

    assign ij_sum = (CNT_W+1)'(i_reg) + (CNT_W+1)'(j_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (ctrl.clr_start) begin
            clr_cnt_reg <= '0;
        end else if (ctrl.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + CELL_AW'(1);
        end
    end

    assign clr_in_pow = (clr_cnt_reg[CELL_AW-1:ADDR_W] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.frm_clr) begin
            frame_cnt_reg <= '0;
        end else if (ctrl.frm_inc && (frame_cnt_reg != '1)) begin
            frame_cnt_reg <= frame_cnt_reg + FRM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_lat) begin
            row_reg <= ADDR_W'(s_row);
            col_reg <= ADDR_W'(s_col);
        end
    end

    assign rc_sum = (CNT_W+1)'(row_reg) + (CNT_W+1)'(col_reg);

    // frame buffers; x is held twice so bins i and i+j read together
    bsa_ram #(.WIDTH(2*SMP_W), .DEPTH(MAX_BINS)) u_xa (
        .aclk(aclk), .wr_en(ctrl.ld_wr), .wr_addr(ADDR_W'(s_bin_index)),
        .wr_data({s_x_real, s_x_imag}), .rd_addr(i_reg[ADDR_W-1:0]), .rd_data(fa_q)
    );
    bsa_ram #(.WIDTH(2*SMP_W), .DEPTH(MAX_BINS)) u_xb (
        .aclk(aclk), .wr_en(ctrl.ld_wr), .wr_addr(ADDR_W'(s_bin_index)),
        .wr_data({s_x_real, s_x_imag}), .rd_addr(ij_sum[ADDR_W-1:0]), .rd_data(fb_q)
    );
    bsa_ram #(.WIDTH(2*SMP_W), .DEPTH(MAX_BINS)) u_y (
        .aclk(aclk), .wr_en(ctrl.ld_wr), .wr_addr(ADDR_W'(s_bin_index)),
        .wr_data({s_y_real, s_y_imag}),
        .rd_addr(ctrl.pw_sel_y ? i_reg[ADDR_W-1:0] : j_reg[ADDR_W-1:0]), .rd_data(fy_q)
    );

    assign xr = fa_q[2*SMP_W-1:SMP_W];
    assign xi = fa_q[SMP_W-1:0];
    assign kr = fb_q[2*SMP_W-1:SMP_W];
    assign ki = fb_q[SMP_W-1:0];
    assign yr = fy_q[2*SMP_W-1:SMP_W];
    assign yi = fy_q[SMP_W-1:0];

    // cell term pipeline
    always_ff @(posedge aclk) begin
        if (ctrl.m1_en) begin
            p1_reg <= xr * yr;
            p2_reg <= xi * yi;
            p3_reg <= xr * yi;
            p4_reg <= xi * yr;
        end
        if (ctrl.m2_en) begin
            if (order2) begin
                a_reg <= 33'(p1_reg) - 33'(p2_reg);
                b_reg <= 33'(p3_reg) + 33'(p4_reg);
            end else begin
                a_reg <= 33'(p1_reg) + 33'(p2_reg);
                b_reg <= 33'(p4_reg) - 33'(p3_reg);
            end
        end
        if (ctrl.m3_en) begin
            q1_reg <= 49'(a_reg) * 49'(kr);
            q2_reg <= 49'(b_reg) * 49'(ki);
            q3_reg <= 49'(b_reg) * 49'(kr);
            q4_reg <= 49'(a_reg) * 49'(ki);
        end
        if (ctrl.m4_en) begin
            if (order2) begin
                tre_reg <= 50'(q1_reg) + 50'(q2_reg);
                tim_reg <= 50'(q3_reg) - 50'(q4_reg);
            end else begin
                tre_reg <= 50'(a_reg);
                tim_reg <= 50'(b_reg);
            end
        end
    end

    assign cr_s   = cr_q;
    assign ci_s   = ci_q;
    assign sre    = 64'(cr_s) + 64'(tre_reg);
    assign sim    = 64'(ci_s) + 64'(tim_reg);
    assign sat_re = sat_cell(sre);
    assign sat_im = sat_cell(sim);

    assign cell_we = ctrl.clr_wr | ctrl.cell_wr;
    assign cell_wa = ctrl.clr_wr ? clr_cnt_reg : {i_reg[ADDR_W-1:0], j_reg[ADDR_W-1:0]};
    assign cell_ra = ctrl.rd_mode ? {row_reg, col_reg}
                                  : {i_reg[ADDR_W-1:0], j_reg[ADDR_W-1:0]};

    bsa_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_re (
        .aclk(aclk), .wr_en(cell_we), .wr_addr(cell_wa),
        .wr_data(ctrl.clr_wr ? '0 : sat_re), .rd_addr(cell_ra), .rd_data(cr_q)
    );
    bsa_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_im (
        .aclk(aclk), .wr_en(cell_we), .wr_addr(cell_wa),
        .wr_data(ctrl.clr_wr ? '0 : sat_im), .rd_addr(cell_ra), .rd_data(ci_q)
    );

    // power sums
    assign pr_s = ctrl.pw_sel_y ? yr : xr;
    assign pm_s = ctrl.pw_sel_y ? yi : xi;

    always_ff @(posedge aclk) begin
        if (ctrl.sq_en) begin
            sq1_reg <= pr_s * pr_s;
            sq2_reg <= pm_s * pm_s;
        end
    end

    assign pw_term = {1'b0, sq1_reg} + {1'b0, sq2_reg};
    assign pw_acc  = ctrl.pw_sel_y ? yp_q : xpa_q;
    assign pw_sum  = {1'b0, pw_acc} + (POW_W+1)'(pw_term);
    assign pw_sat  = pw_sum[POW_W] ? '1 : pw_sum[POW_W-1:0];

    assign xp_we = (ctrl.clr_wr & clr_in_pow) | (ctrl.pw_wr & ~ctrl.pw_sel_y);
    assign yp_we = (ctrl.clr_wr & clr_in_pow) | (ctrl.pw_wr & ctrl.pw_sel_y);
    assign pw_wa = ctrl.clr_wr ? clr_cnt_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign pw_wd = ctrl.clr_wr ? '0 : pw_sat;

    bsa_ram #(.WIDTH(POW_W), .DEPTH(MAX_BINS)) u_xpa (
        .aclk(aclk), .wr_en(xp_we), .wr_addr(pw_wa), .wr_data(pw_wd),
        .rd_addr(ctrl.rd_mode ? row_reg : i_reg[ADDR_W-1:0]), .rd_data(xpa_q)
    );
    bsa_ram #(.WIDTH(POW_W), .DEPTH(MAX_BINS)) u_xpb (
        .aclk(aclk), .wr_en(xp_we), .wr_addr(pw_wa), .wr_data(pw_wd),
        .rd_addr(rc_sum[ADDR_W-1:0]), .rd_data(xpb_q)
    );
    bsa_ram #(.WIDTH(POW_W), .DEPTH(MAX_BINS)) u_yp (
        .aclk(aclk), .wr_en(yp_we), .wr_addr(pw_wa), .wr_data(pw_wd),
        .rd_addr(ctrl.rd_mode ? col_reg : i_reg[ADDR_W-1:0]), .rd_data(yp_q)
    );

    // output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_sum_real   <= cr_q;
            m_sum_imag   <= ci_q;
            m_row_power  <= xpa_q;
            m_col_power  <= yp_q;
            m_diag_power <= (rc_sum < (CNT_W+1)'(nx)) ? xpb_q : '0;
            m_frames     <= frame_cnt_reg;
        end
    end

    assign m_valid = m_valid_reg;

    assign status.cells_done = (i_reg >= nx) || (ny == '0);
    assign status.skip       = order2 && (ij_sum >= (CNT_W+1)'(nx));
    assign status.pw_x_done  = (i_reg >= nx);
    assign status.pw_y_done  = (i_reg >= ny);
    assign status.clr_last   = (clr_cnt_reg == '1);
    assign status.order2     = order2;
    assign status.out_busy   = m_valid_reg & ~m_ready;

endmodule
`default_nettype wire

>>> rtl/core/bsa_ctrl.sv
// Controller state machine: command decode, clearing pass, matrix and power sweeps.
`timescale 1ns / 1ps
`default_nettype none
module bsa_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    input  wire logic [bsa_pkg::CMD_W-1:0] s_command,
    input  wire logic                      s_frame_end,
    output logic                           s_ready,
    output bsa_pkg::ctrl_t                 ctrl,
    input  wire bsa_pkg::status_t          status
);
    import bsa_pkg::*;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_RD_A   = 4'd2;
    localparam logic [3:0] ST_RD_B   = 4'd3;
    localparam logic [3:0] ST_C_RD   = 4'd4;
    localparam logic [3:0] ST_C_M1   = 4'd5;
    localparam logic [3:0] ST_C_M2   = 4'd6;
    localparam logic [3:0] ST_C_M3   = 4'd7;
    localparam logic [3:0] ST_C_M4   = 4'd8;
    localparam logic [3:0] ST_C_WR   = 4'd9;
    localparam logic [3:0] ST_PX_RD  = 4'd10;
    localparam logic [3:0] ST_PX_MUL = 4'd11;
    localparam logic [3:0] ST_PX_WR  = 4'd12;
    localparam logic [3:0] ST_PY_RD  = 4'd13;
    localparam logic [3:0] ST_PY_MUL = 4'd14;
    localparam logic [3:0] ST_PY_WR  = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR: begin
                ctrl.clr_wr = 1'b1;
                if (status.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_command)
                        CMD_LOAD: begin
                            ctrl.ld_wr = 1'b1;
                            if (s_frame_end) begin
                                ctrl.idx_clr = 1'b1;
                                state_next   = ST_C_RD;
                            end
                        end
                        CMD_READ: begin
                            ctrl.rd_lat = 1'b1;
                            state_next  = ST_RD_A;
                        end
                        CMD_CLEAR: begin
                            ctrl.clr_start = 1'b1;
                            ctrl.frm_clr   = 1'b1;
                            state_next     = ST_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_A: begin
                ctrl.rd_mode = 1'b1;
                state_next   = ST_RD_B;
            end
            ST_RD_B: begin
                ctrl.rd_mode = 1'b1;
                if (!status.out_busy) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_C_RD: begin
                if (status.cells_done) begin
                    ctrl.idx_clr = 1'b1;
                    state_next   = ST_PX_RD;
                end else if (status.skip) begin
                    ctrl.cell_next = 1'b1;
                end else begin
                    state_next = ST_C_M1;
                end
            end
            ST_C_M1: begin
                ctrl.m1_en = 1'b1;
                state_next = ST_C_M2;
            end
            ST_C_M2: begin
                ctrl.m2_en = 1'b1;
                state_next = status.order2 ? ST_C_M3 : ST_C_M4;
            end
            ST_C_M3: begin
                ctrl.m3_en = 1'b1;
                state_next = ST_C_M4;
            end
            ST_C_M4: begin
                ctrl.m4_en = 1'b1;
                state_next = ST_C_WR;
            end
            ST_C_WR: begin
                ctrl.cell_wr   = 1'b1;
                ctrl.cell_next = 1'b1;
                state_next     = ST_C_RD;
            end
            ST_PX_RD: begin
                if (status.pw_x_done) begin
                    ctrl.idx_clr = 1'b1;
                    state_next   = ST_PY_RD;
                end else begin
                    state_next = ST_PX_MUL;
                end
            end
            ST_PX_MUL: begin
                ctrl.sq_en = 1'b1;
                state_next = ST_PX_WR;
            end
            ST_PX_WR: begin
                ctrl.pw_wr = 1'b1;
                state_next = ST_PX_RD;
            end
            ST_PY_RD: begin
                ctrl.pw_sel_y = 1'b1;
                if (status.pw_y_done) begin
                    ctrl.frm_inc = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_PY_MUL;
                end
            end
            ST_PY_MUL: begin
                ctrl.pw_sel_y = 1'b1;
                ctrl.sq_en    = 1'b1;
                state_next    = ST_PY_WR;
            end
            ST_PY_WR: begin
                ctrl.pw_sel_y = 1'b1;
                ctrl.pw_wr    = 1'b1;
                state_next    = ST_PY_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/bispectrum_accumulator.sv
// A load without frame end leaves s_ready high; a read passes RD_A, then RD_B, which registers
// the output word once the previous one is not stalled. Frame end sweep: each x_bins*y_bins
// cell passes C_RD, M1, M2, M3, M4, WR in order 2 (no M3 in order 1, a skipped cell leaves
// from C_RD), then each x and y power bin passes RD, MUL, WR. Reads, clears and frame ends
// hold s_ready low, as do reset and clear: a clearing pass over all 4096 cell addresses.
// Frame buffers are not cleared; configuration resets to order 1, 64 x bins, 64 y bins.
`timescale 1ns / 1ps
`default_nettype none
module bispectrum_accumulator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsa_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bsa_pkg::CMD_W-1:0]     s_command,
    input  wire logic [bsa_pkg::BIN_W-1:0]     s_bin_index,
    input  wire logic signed [bsa_pkg::SMP_W-1:0] s_x_real,
    input  wire logic signed [bsa_pkg::SMP_W-1:0] s_x_imag,
    input  wire logic signed [bsa_pkg::SMP_W-1:0] s_y_real,
    input  wire logic signed [bsa_pkg::SMP_W-1:0] s_y_imag,
    input  wire logic                          s_frame_end,
    input  wire logic [bsa_pkg::BIN_W-1:0]     s_row,
    input  wire logic [bsa_pkg::BIN_W-1:0]     s_col,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [bsa_pkg::CELL_W-1:0]  m_sum_real,
    output logic signed [bsa_pkg::CELL_W-1:0]  m_sum_imag,
    output logic [bsa_pkg::POW_W-1:0]          m_row_power,
    output logic [bsa_pkg::POW_W-1:0]          m_col_power,
    output logic [bsa_pkg::POW_W-1:0]          m_diag_power,
    output logic [bsa_pkg::FRM_W-1:0]          m_frames
);
    import bsa_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    bsa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_command(s_command), .s_frame_end(s_frame_end),
        .s_ready(s_ready), .ctrl(ctrl), .status(status)
    );

    bsa_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_bin_index(s_bin_index),
        .s_x_real(s_x_real), .s_x_imag(s_x_imag),
        .s_y_real(s_y_real), .s_y_imag(s_y_imag),
        .s_row(s_row), .s_col(s_col),
        .m_ready(m_ready), .m_valid(m_valid),
        .m_sum_real(m_sum_real), .m_sum_imag(m_sum_imag),
        .m_row_power(m_row_power), .m_col_power(m_col_power),
        .m_diag_power(m_diag_power), .m_frames(m_frames),
        .ctrl(ctrl), .status(status)
    );

endmodule
`default_nettype wire

>>> rtl/core/bsa_checker.sv
// Port-level assertions for the accumulator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bsa_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [bsa_pkg::CMD_W-1:0]     s_command,
    input wire logic                          s_frame_end,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [bsa_pkg::CELL_W-1:0]    m_sum_real,
    input wire logic [bsa_pkg::FRM_W-1:0]     m_frames
);
    import bsa_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum_real) && $stable(m_frames))
        else $error("output word changed while stalled");

    // reset starts the clearing pass with no word pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block ready or output valid right after reset");

    // reads, clears and frame ends keep the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_READ || s_command == CMD_CLEAR ||
        (s_command == CMD_LOAD && s_frame_end)) |=> !s_ready)
        else $error("input ready right after a multi-cycle word");

    // a result word is produced only while the block is busy
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("output word without a read in progress");

endmodule

bind bispectrum_accumulator bsa_checker u_bsa_checker (.*);
`default_nettype wire

>>> tb/tb_bispectrum_accumulator.sv
// Self-checking testbench for the bispectrum accumulator: directed and random words.
`timescale 1ns / 1ps
`default_nettype none
module tb_bispectrum_accumulator;
    import bsa_pkg::*;

    localparam longint CELL_HI  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint CELL_LO  = -CELL_HI - 1;
    localparam longint POW_HI   = 64'h000F_FFFF_FFFF_FFFF;
    localparam int     FRM_HI   = 1048575;
    localparam longint CYC_LIMIT = 3_000_000;

    typedef struct packed {
        logic [CELL_W-1:0] sum_real;
        logic [CELL_W-1:0] sum_imag;
        logic [POW_W-1:0]  row_power;
        logic [POW_W-1:0]  col_power;
        logic [POW_W-1:0]  diag_power;
        logic [FRM_W-1:0]  frames;
    } cell_read_t;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic s_valid, s_ready;
    logic [CMD_W-1:0] s_command;
    logic [BIN_W-1:0] s_bin_index;
    logic signed [SMP_W-1:0] s_x_real, s_x_imag, s_y_real, s_y_imag;
    logic s_frame_end;
    logic [BIN_W-1:0] s_row, s_col;
    logic m_valid, m_ready;
    logic signed [CELL_W-1:0] m_sum_real, m_sum_imag;
    logic [POW_W-1:0] m_row_power, m_col_power, m_diag_power;
    logic [FRM_W-1:0] m_frames;

    bispectrum_accumulator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_bin_index(s_bin_index), .s_x_real(s_x_real), .s_x_imag(s_x_imag),
        .s_y_real(s_y_real), .s_y_imag(s_y_imag), .s_frame_end(s_frame_end),
        .s_row(s_row), .s_col(s_col),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sum_real(m_sum_real), .m_sum_imag(m_sum_imag),
        .m_row_power(m_row_power), .m_col_power(m_col_power),
        .m_diag_power(m_diag_power), .m_frames(m_frames)
    );

    // mirror of the accumulator state
    logic [ORDER_W-1:0] acc_order;
    logic [BINS_W-1:0]  acc_x_bins, acc_y_bins;
    longint xbuf_re [MAX_BINS], xbuf_im [MAX_BINS];
    longint ybuf_re [MAX_BINS], ybuf_im [MAX_BINS];
    logic [MAX_BINS-1:0] bin_loaded;
    longint cell_re [CELLS], cell_im [CELLS];
    longint xpow [MAX_BINS], ypow [MAX_BINS];
    int frame_cnt;

    cell_read_t pending_reads[$];
    int errors, words_sent, reads_checked, sweeps_done, clears_done;
    int sender_gap_pct, receiver_stall_pct;
    int busy_bound;
    int frame_ptr;
    longint cycles;

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding",
                     cycles, pending_reads.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (receiver_stall_pct > 0 && $urandom_range(0, 99) < receiver_stall_pct)
            m_ready <= 1'b0;
        else
            m_ready <= 1'b1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        cell_read_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("unexpected result word", 64'(m_frames), 64'd0);
            end else begin
                e = pending_reads.pop_front();
                reads_checked++;
                if (m_sum_real !== e.sum_real)
                    report_mismatch("sum_real", 64'(m_sum_real), 64'(e.sum_real));
                if (m_sum_imag !== e.sum_imag)
                    report_mismatch("sum_imag", 64'(m_sum_imag), 64'(e.sum_imag));
                if (m_row_power !== e.row_power)
                    report_mismatch("row_power", 64'(m_row_power), 64'(e.row_power));
                if (m_col_power !== e.col_power)
                    report_mismatch("col_power", 64'(m_col_power), 64'(e.col_power));
                if (m_diag_power !== e.diag_power)
                    report_mismatch("diag_power", 64'(m_diag_power), 64'(e.diag_power));
                if (m_frames !== e.frames)
                    report_mismatch("frames", 64'(m_frames), 64'(e.frames));
            end
        end
    end

    function automatic int eff_bins(input logic [BINS_W-1:0] n);
        return (n > MAX_BINS) ? MAX_BINS : int'(n);
    endfunction

    function automatic longint clamp_cell(input longint acc, input longint add);
        longint s;
        s = acc + add;
        if (s > CELL_HI) s = CELL_HI;
        if (s < CELL_LO) s = CELL_LO;
        return s;
    endfunction

    function automatic longint clamp_pow(input longint acc, input longint add);
        longint s;
        s = acc + add;
        return (s > POW_HI) ? POW_HI : s;
    endfunction

    task automatic clear_sums();
        for (int k = 0; k < CELLS; k++) begin
            cell_re[k] = 0;
            cell_im[k] = 0;
        end
        for (int k = 0; k < MAX_BINS; k++) begin
            xpow[k] = 0;
            ypow[k] = 0;
        end
        frame_cnt = 0;
    endtask

    task automatic sweep_matrix();
        int nx, ny, c;
        longint pr, pi, re, im;
        nx = eff_bins(acc_x_bins);
        ny = eff_bins(acc_y_bins);
        for (int i = 0; i < nx; i++) begin
            for (int j = 0; j < ny; j++) begin
                c = i * MAX_BINS + j;
                if (acc_order == ORDER_TRIPLE) begin
                    if (i + j >= nx) continue;
                    pr = xbuf_re[i] * ybuf_re[j] - xbuf_im[i] * ybuf_im[j];
                    pi = xbuf_re[i] * ybuf_im[j] + xbuf_im[i] * ybuf_re[j];
                    re = pr * xbuf_re[i+j] + pi * xbuf_im[i+j];
                    im = pi * xbuf_re[i+j] - pr * xbuf_im[i+j];
                end else begin
                    re = xbuf_re[i] * ybuf_re[j] + xbuf_im[i] * ybuf_im[j];
                    im = xbuf_im[i] * ybuf_re[j] - xbuf_re[i] * ybuf_im[j];
                end
                cell_re[c] = clamp_cell(cell_re[c], re);
                cell_im[c] = clamp_cell(cell_im[c], im);
            end
        end
        for (int i = 0; i < nx; i++)
            xpow[i] = clamp_pow(xpow[i], xbuf_re[i]*xbuf_re[i] + xbuf_im[i]*xbuf_im[i]);
        for (int j = 0; j < ny; j++)
            ypow[j] = clamp_pow(ypow[j], ybuf_re[j]*ybuf_re[j] + ybuf_im[j]*ybuf_im[j]);
        if (frame_cnt < FRM_HI) frame_cnt++;
        sweeps_done++;
        busy_bound = 6 * nx * ny + 3 * (nx + ny) + 64;
    endtask

    // apply one accepted word to the mirror
    task automatic accumulate_word();
        cell_read_t e;
        int r, c, nx;
        busy_bound = 16;
        case (s_command)
            CMD_LOAD: begin
                xbuf_re[s_bin_index] = longint'(s_x_real);
                xbuf_im[s_bin_index] = longint'(s_x_imag);
                ybuf_re[s_bin_index] = longint'(s_y_real);
                ybuf_im[s_bin_index] = longint'(s_y_imag);
                bin_loaded[s_bin_index] = 1'b1;
                if (s_frame_end) sweep_matrix();
            end
            CMD_CLEAR: begin
                clear_sums();
                clears_done++;
                busy_bound = 4400;
            end
            CMD_READ: begin
                r = s_row;
                c = s_col;
                nx = eff_bins(acc_x_bins);
                e.sum_real   = cell_re[r*MAX_BINS + c][CELL_W-1:0];
                e.sum_imag   = cell_im[r*MAX_BINS + c][CELL_W-1:0];
                e.row_power  = xpow[r][POW_W-1:0];
                e.col_power  = ypow[c][POW_W-1:0];
                e.diag_power = (r + c < nx) ? xpow[r+c][POW_W-1:0] : '0;
                e.frames     = frame_cnt[FRM_W-1:0];
                pending_reads = {pending_reads, e};
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BIN_W-1:0] idx,
                             input logic [SMP_W-1:0] xr, input logic [SMP_W-1:0] xi,
                             input logic [SMP_W-1:0] yr, input logic [SMP_W-1:0] yi,
                             input logic fe, input logic [BIN_W-1:0] row,
                             input logic [BIN_W-1:0] col);
        if (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_bin_index <= idx;
        s_x_real    <= xr;
        s_x_imag    <= xi;
        s_y_real    <= yr;
        s_y_imag    <= yi;
        s_frame_end <= fe;
        s_row       <= row;
        s_col       <= col;
        do @(posedge aclk); while (!s_ready);
        accumulate_word();
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (busy_bound) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ORDER:  acc_order  = val[ORDER_W-1:0];
            REG_X_BINS: acc_x_bins = val[BINS_W-1:0];
            REG_Y_BINS: acc_y_bins = val[BINS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(input int ord, input int xb, input int yb);
        drain();
        write_reg(REG_ORDER, CFG_W'(ord));
        write_reg(REG_X_BINS, CFG_W'(xb));
        write_reg(REG_Y_BINS, CFG_W'(yb));
        frame_ptr = 0;
    endtask

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic int needed_bins();
        int nx, ny;
        nx = eff_bins(acc_x_bins);
        ny = eff_bins(acc_y_bins);
        return (nx > ny) ? nx : ny;
    endfunction

    function automatic logic sweep_safe();
        for (int k = 0; k < needed_bins(); k++)
            if (!bin_loaded[k]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic read_cell(input int row, input int col);
        send_word(CMD_READ, BIN_W'($urandom), rand_sample(), rand_sample(), rand_sample(),
                  rand_sample(), 1'($urandom), BIN_W'(row), BIN_W'(col));
    endtask

    // one complete frame, bins loaded in order, frame end on the last
    task automatic load_frame(input logic extremes);
        int n;
        logic [SMP_W-1:0] a, b, c, d;
        n = needed_bins();
        if (n == 0) n = 1;
        for (int k = 0; k < n; k++) begin
            if (extremes) begin
                a = (k % 2) ? 16'h8000 : 16'h7FFF;
                b = (k % 3) ? 16'h7FFF : 16'h8000;
                c = (k % 2) ? 16'h7FFF : 16'h8000;
                d = 16'h8000;
            end else begin
                a = rand_sample(); b = rand_sample();
                c = rand_sample(); d = rand_sample();
            end
            send_word(CMD_LOAD, BIN_W'(k), a, b, c, d, k == n - 1,
                      BIN_W'($urandom), BIN_W'($urandom));
        end
    endtask

    task automatic read_some(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 1))
                read_cell($urandom_range(0, 63), $urandom_range(0, 63));
            else
                read_cell($urandom_range(0, needed_bins()), $urandom_range(0, needed_bins()));
        end
    endtask

    task automatic test_after_reset();
        read_cell(0, 0);
        read_cell(63, 63);
    endtask

    task automatic test_cross_extremes();
        configure(ORDER_CROSS, 3, 2);
        load_frame(1'b1);
        load_frame(1'b1);
        read_cell(0, 0); read_cell(2, 1); read_cell(1, 1); read_cell(2, 0);
        read_cell(3, 2); read_cell(63, 0);
    endtask

    task automatic test_triple_product();
        configure(ORDER_TRIPLE, 4, 3);
        load_frame(1'b1);
        load_frame(1'b0);
        read_cell(0, 0); read_cell(1, 2); read_cell(2, 2); read_cell(3, 1);
        read_cell(0, 3); read_cell(3, 0);
    endtask

    task automatic test_unknown_and_clear();
        send_word(2'd3, '1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, '1, '1);
        read_cell(1, 1);
        send_word(CMD_CLEAR, '0, '0, '0, '0, '0, 1'b0, '0, '0);
        read_cell(1, 1);
        read_cell(0, 0);
    endtask

    task automatic test_bin_count_edges();
        // zero x bins still counts the frame and sweeps y power
        configure(ORDER_CROSS, 0, 2);
        load_frame(1'b0);
        read_cell(0, 1);
        configure(ORDER_TRIPLE, 1, 64);
        load_frame(1'b0);
        read_cell(0, 63); read_cell(0, 0);
    endtask

    task automatic test_full_matrix();
        configure(ORDER_TRIPLE, 64, 64);
        load_frame(1'b0);
        read_cell(63, 0); read_cell(0, 63); read_cell(31, 32); read_cell(32, 32);
        // above the bin limit acts as the limit; order 0 acts as cross
        configure(0, 127, 100);
        load_frame(1'b1);
        read_cell(63, 63); read_cell(10, 53);
        configure(3, 64, 64);
        send_word(CMD_LOAD, 6'd63, 16'h1234, 16'hEDCB, 16'h8000, 16'h7FFF, 1'b1, '0, '0);
        read_cell(63, 63); read_cell(62, 1);
    endtask

    task automatic random_word();
        int pick, n;
        pick = $urandom_range(0, 99);
        n = needed_bins();
        if (n == 0) n = 1;
        if (pick < 70) begin
            send_word(CMD_LOAD, BIN_W'(frame_ptr), rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), frame_ptr == n - 1,
                      BIN_W'($urandom), BIN_W'($urandom));
            frame_ptr = (frame_ptr >= n - 1) ? 0 : frame_ptr + 1;
        end else if (pick < 86) begin
            read_some(1);
        end else if (pick < 94) begin
            // stray load: frame end only when every swept bin holds data
            send_word(CMD_LOAD, BIN_W'($urandom), rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), sweep_safe() && $urandom_range(0, 1),
                      BIN_W'($urandom), BIN_W'($urandom));
        end else if (pick < 98) begin
            send_word(2'd3, BIN_W'($urandom), rand_sample(), rand_sample(), rand_sample(),
                      rand_sample(), 1'($urandom), BIN_W'($urandom), BIN_W'($urandom));
        end else if (pick < 99) begin
            send_word(CMD_CLEAR, BIN_W'($urandom), rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), 1'($urandom), BIN_W'($urandom),
                      BIN_W'($urandom));
        end else begin
            read_some(1);
        end
    endtask

    task automatic test_random_traffic();
        int gap_tbl [4] = '{0, 47, 0, 6};
        int stall_tbl [4] = '{0, 0, 47, 6};
        for (int ph = 0; ph < 12; ph++) begin
            configure($urandom_range(0, 3), $urandom_range(0, 9), $urandom_range(0, 9));
            sender_gap_pct     = gap_tbl[ph % 4];
            receiver_stall_pct = stall_tbl[ph % 4];
            for (int k = 0; k < 130; k++) begin
                random_word();
                if (ph == 5 && k == 60) begin
                    s_valid <= 1'b0;
                    while (pending_reads.size() != 0) @(posedge aclk);
                end
            end
            read_some(8);
        end
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        cycles = 0; errors = 0; words_sent = 0; reads_checked = 0;
        sweeps_done = 0; clears_done = 0; sender_gap_pct = 0; receiver_stall_pct = 0;
        busy_bound = 4400; frame_ptr = 0;
        acc_order = ORDER_CROSS; acc_x_bins = 7'd64; acc_y_bins = 7'd64;
        bin_loaded = '0;
        for (int k = 0; k < MAX_BINS; k++) begin
            xbuf_re[k] = 0; xbuf_im[k] = 0; ybuf_re[k] = 0; ybuf_im[k] = 0;
        end
        clear_sums();
        aresetn <= 1'b0; cfg_wr_en <= 1'b0; cfg_index <= '0; cfg_data <= '0;
        s_valid <= 1'b0; s_command <= CMD_LOAD; s_bin_index <= '0;
        s_x_real <= '0; s_x_imag <= '0; s_y_real <= '0; s_y_imag <= '0;
        s_frame_end <= 1'b0; s_row <= '0; s_col <= '0; m_ready <= 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        test_cross_extremes();
        test_triple_product();
        test_unknown_and_clear();
        test_bin_count_edges();
        test_full_matrix();
        test_random_traffic();

        drain();
        $display("covered %0d words: %0d reads checked, %0d frame sweeps, %0d clears",
                 words_sent, reads_checked, sweeps_done, clears_done);
        $display("orders cross and triple, bin counts 0 to 127, four idle patterns");
        if (errors == 0 && pending_reads.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
